### rtl/isoep_pkg.sv
package isoep_pkg;

   localparam logic [7:0] CHAR_NUL     = 8'd0;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'd48;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'd57;

   localparam logic [3:0] POS_YEAR_END   = 4'd3;
   localparam logic [3:0] POS_MONTH_END  = 4'd5;
   localparam logic [3:0] POS_DAY_END    = 4'd7;
   localparam logic [3:0] POS_HOUR_END   = 4'd9;
   localparam logic [3:0] POS_MINUTE_END = 4'd11;
   localparam logic [3:0] POS_SECOND_END = 4'd13;

   localparam int           MONTH_CARRY_MAX = 127 / 12;
   localparam logic [6:0]   MONTHS_PER_YEAR = 7'd12;
   localparam logic [3:0]   DECEMBER_IDX    = 4'd11;
   localparam logic [13:0]  YEAR_BIAS       = 14'd400;
   localparam logic [24:0]  RECIP_25        = 25'd5243;
   localparam int           Q100_LSB        = 17;
   localparam logic [11:0]  CENTURY_QUARTERS = 12'd25;

   // days since 1970 = 365 * biased_year + leaps_before + yday - DAY_OFFSET
   localparam logic [38:0]  DAYS_PER_YEAR  = 39'd365;
   localparam logic [38:0]  DAY_OFFSET     = 39'd865625;
   localparam logic [38:0]  HOURS_PER_DAY  = 39'd24;
   localparam logic [38:0]  MINS_PER_HOUR  = 39'd60;

   localparam logic [8:0] DBM_COMMON [0:12] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
      9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365};
   localparam logic [8:0] DBM_LEAP [0:12] = '{
      9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
      9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366};

   function automatic logic [8:0] days_before_month(input logic leap, input logic [3:0] idx);
      return leap ? DBM_LEAP[idx] : DBM_COMMON[idx];
   endfunction

   typedef enum logic [2:0] {
      ST_COLLECT,
      ST_SPLIT,
      ST_DIV,
      ST_DAYS,
      ST_HOUR,
      ST_MINUTE,
      ST_SECOND
   } fsm_state_type;

   typedef struct packed {
      logic take_char;
      logic do_split;
      logic do_div;
      logic do_days;
      logic do_hour;
      logic do_minute;
      logic load_out;
   } isoep_cmd_type;

   typedef struct packed {
      logic last_char;
      logic out_free;
   } isoep_status_type;

endpackage

### rtl/isoep_if.sv
interface isoep_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink (input valid, input char_code, output ready);
endinterface

interface isoep_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [38:0] epoch_seconds;

   modport source (output valid, output epoch_seconds, input ready);
   modport sink (input valid, input epoch_seconds, output ready);
endinterface

### rtl/iso_digits_to_epoch_seconds.sv
// Converts a 14-character ASCII timestamp YYYYMMDDHHMMSS, taken one character
// per item on req_ch, into signed seconds since 1970-01-01 00:00:00 UTC
// (proleptic Gregorian calendar), given as one item on rsp_ch after the 14th
// character. Each field reads decimal digits up to its first non-digit; a NUL
// makes that and all later positions read as zero; month zero means December
// of the year before and day zero the day before the first. Characters 1 to
// 13 are taken at one per cycle. After the 14th, the block takes no character
// while a sequencer runs the conversion steps in order: month split, leap-year
// division by reciprocal multiply, day count, then one shared multiply-add
// unit for hours, minutes and seconds. The result waits in an output register
// while the next timestamp streams in, and the final conversion step holds
// only if that register is still full.
module iso_digits_to_epoch_seconds
   import isoep_pkg::*;
(
   input logic          clock,
   input logic          reset,
   isoep_req_if.sink    req_ch,
   isoep_rsp_if.source  rsp_ch
);

   isoep_cmd_type    cmd;
   isoep_status_type status;

   isoep_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   isoep_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .char_code     (req_ch.char_code),
      .rsp_ready     (rsp_ch.ready),
      .rsp_valid     (rsp_ch.valid),
      .epoch_seconds (rsp_ch.epoch_seconds)
   );

endmodule

### rtl/isoep_ctrl.sv
module isoep_ctrl
   import isoep_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  isoep_status_type status,
   output isoep_cmd_type    cmd
);

   fsm_state_type state_ff;
   fsm_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_COLLECT: begin
            if (req_valid && status.last_char) begin
               state_in = ST_SPLIT;
            end
         end
         ST_SPLIT:  state_in = ST_DIV;
         ST_DIV:    state_in = ST_DAYS;
         ST_DAYS:   state_in = ST_HOUR;
         ST_HOUR:   state_in = ST_MINUTE;
         ST_MINUTE: state_in = ST_SECOND;
         ST_SECOND: begin
            if (status.out_free) begin
               state_in = ST_COLLECT;
            end
         end
         default:   state_in = ST_COLLECT;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_COLLECT: begin
            req_ready     = 1'b1;
            cmd.take_char = req_valid;
         end
         ST_SPLIT:  cmd.do_split  = 1'b1;
         ST_DIV:    cmd.do_div    = 1'b1;
         ST_DAYS:   cmd.do_days   = 1'b1;
         ST_HOUR:   cmd.do_hour   = 1'b1;
         ST_MINUTE: cmd.do_minute = 1'b1;
         ST_SECOND: cmd.load_out  = status.out_free;
         default:   cmd           = '0;
      endcase
   end

   a_last_char_converts: assert property (@(posedge clock) disable iff (reset)
      (cmd.take_char && status.last_char) |=> (state_ff == ST_SPLIT && !req_ready))
      else $error("conversion did not start after last character");

   a_fixed_sequence: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SPLIT) |=> ##4 (state_ff == ST_SECOND))
      else $error("conversion steps out of order");

endmodule

### rtl/isoep_dp.sv
module isoep_dp
   import isoep_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  isoep_cmd_type      cmd,
   output isoep_status_type   status,
   input  logic [7:0]         char_code,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic signed [38:0] epoch_seconds
);

   logic [3:0]  pos_ff, pos_in;
   logic        term_ff, term_in;
   logic [13:0] field_ff, field_in;
   logic        stopped_ff, stopped_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [13:0] year_ff;
   logic [6:0]  month_ff, day_ff, hour_ff, minute_ff, second_ff;

   logic [13:0] p_ff;
   logic [3:0]  mon_idx_ff;
   logic [11:0] q4n_ff, q4p_ff;
   logic [6:0]  q100n_ff, q100p_ff;
   logic [38:0] mac_ff;
   logic [38:0] out_ff;

   logic [7:0]  char_eff;
   logic        is_digit;
   logic [13:0] field_next;
   logic        field_end;
   logic        last_pos;

   logic [6:0]  mon_x;
   logic [3:0]  year_carry;
   logic [6:0]  mon_rem;
   logic [13:0] p_in;
   logic [3:0]  mon_idx_in;

   logic [13:0] n_year;
   logic [24:0] prod_n, prod_p;

   logic        leap;
   logic [11:0] leaps;
   logic [38:0] days_val;

   logic [38:0] mac_k;
   logic [6:0]  mac_add;
   logic [38:0] mac_out;

   // character parsing
   always_comb begin
      char_eff   = term_ff ? CHAR_NUL : char_code;
      is_digit   = !stopped_ff && (char_eff inside {[CHAR_DIGIT_0:CHAR_DIGIT_9]});
      field_next = is_digit ? 14'(field_ff * 14'd10 + 14'(char_eff - CHAR_DIGIT_0)) : field_ff;
      field_end  = pos_ff inside {POS_YEAR_END, POS_MONTH_END, POS_DAY_END,
                                  POS_HOUR_END, POS_MINUTE_END, POS_SECOND_END};
      last_pos   = (pos_ff == POS_SECOND_END);

      pos_in     = pos_ff;
      term_in    = term_ff;
      field_in   = field_ff;
      stopped_in = stopped_ff;
      if (cmd.take_char) begin
         pos_in     = last_pos ? 4'd0 : pos_ff + 4'd1;
         term_in    = !last_pos && (term_ff || (char_eff == CHAR_NUL));
         field_in   = field_end ? 14'd0 : field_next;
         stopped_in = !field_end && (stopped_ff || !is_digit);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 4'd0;
         term_ff      <= 1'b0;
         field_ff     <= 14'd0;
         stopped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         term_ff      <= term_in;
         field_ff     <= field_in;
         stopped_ff   <= stopped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_char) begin
         case (pos_ff)
            POS_YEAR_END:   year_ff   <= field_next;
            POS_MONTH_END:  month_ff  <= field_next[6:0];
            POS_DAY_END:    day_ff    <= field_next[6:0];
            POS_HOUR_END:   hour_ff   <= field_next[6:0];
            POS_MINUTE_END: minute_ff <= field_next[6:0];
            POS_SECOND_END: second_ff <= field_next[6:0];
            default: ;
         endcase
      end
   end

   // month to year carry and month of year; year biased by 400 to stay positive
   always_comb begin
      mon_x      = month_ff - 7'd1;
      year_carry = 4'd0;
      for (int k = 1; k <= MONTH_CARRY_MAX; k++) begin
         if (mon_x >= 7'(12 * k)) begin
            year_carry = year_carry + 4'd1;
         end
      end
      mon_rem = mon_x - 7'(7'(year_carry) * MONTHS_PER_YEAR);
      if (month_ff == 7'd0) begin
         p_in       = year_ff + YEAR_BIAS - 14'd1;
         mon_idx_in = DECEMBER_IDX;
      end else begin
         p_in       = year_ff + YEAR_BIAS + 14'(year_carry);
         mon_idx_in = mon_rem[3:0];
      end
   end

   // quarters and centuries of the biased year and the year before
   always_comb begin
      n_year = p_ff - 14'd1;
      prod_n = 25'(n_year[13:2]) * RECIP_25;
      prod_p = 25'(p_ff[13:2]) * RECIP_25;
   end

   always_comb begin
      leap = (p_ff[1:0] == 2'b00)
          && ((q4p_ff != 12'(q100p_ff) * CENTURY_QUARTERS) || (q100p_ff[1:0] == 2'b00));
      leaps = q4n_ff - 12'(q100n_ff) + 12'(q100n_ff[6:2]);
      days_val = 39'(p_ff) * DAYS_PER_YEAR + 39'(leaps)
               + 39'(days_before_month(leap, mon_idx_ff)) + 39'(day_ff) - DAY_OFFSET;
   end

   // shared multiply-add: days -> hours -> minutes -> seconds
   always_comb begin
      mac_k   = cmd.do_hour ? HOURS_PER_DAY : MINS_PER_HOUR;
      mac_add = cmd.do_hour ? hour_ff : (cmd.do_minute ? minute_ff : second_ff);
      mac_out = mac_ff * mac_k + 39'(mac_add);
   end

   always_ff @(posedge clock) begin
      if (cmd.do_split) begin
         p_ff       <= p_in;
         mon_idx_ff <= mon_idx_in;
      end
      if (cmd.do_div) begin
         q4n_ff   <= n_year[13:2];
         q4p_ff   <= p_ff[13:2];
         q100n_ff <= prod_n[Q100_LSB +: 7];
         q100p_ff <= prod_p[Q100_LSB +: 7];
      end
      if (cmd.do_days) begin
         mac_ff <= days_val;
      end else if (cmd.do_hour || cmd.do_minute) begin
         mac_ff <= mac_out;
      end
      if (cmd.load_out) begin
         out_ff <= mac_out;
      end
   end

   assign status.last_char = last_pos;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign epoch_seconds    = signed'(out_ff);

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_SECOND_END)
      else $error("character position out of range");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before taken");

   a_parse_cleared: assert property (@(posedge clock) disable iff (reset)
      (cmd.take_char && last_pos) |=> (pos_ff == 4'd0 && !term_ff && field_ff == 14'd0))
      else $error("parser not cleared after last character");

endmodule
